// ----- src/ccf_pkg.sv -----
// ----------------------------------------------------------------------------
// ccf_pkg
// Shared types and constants of the camera command framer: payload structs,
// configuration set, frame descriptor and command codes.
// ----------------------------------------------------------------------------
package ccf_pkg;

    localparam int unsigned FRAME_MAX_BYTES = 7;
    localparam int unsigned NBYTES_W        = $clog2(FRAME_MAX_BYTES + 1);
    localparam int unsigned CFG_INDEX_W     = 3;
    localparam int unsigned CFG_DATA_W      = 16;

    localparam logic [1:0] CMD_CONTROL  = 2'd0;
    localparam logic [1:0] CMD_BLOCK    = 2'd1;
    localparam logic [1:0] CMD_RESPONSE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_BYTE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TYPE_BYTE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SNAPSHOT_CODE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_CODE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_LENGTH  = 3'd4;

    localparam logic [7:0]  ACK_FIRST          = 8'h8E;
    localparam logic [7:0]  ACK_SECOND         = 8'h01;
    localparam logic [7:0]  ACK_THIRD          = 8'h00;
    localparam logic [7:0]  CODE_INIT_SET      = 8'hFF;
    localparam logic [7:0]  CODE_INIT_CLEAR    = 8'h00;
    localparam logic [7:0]  BLOCK_PAD_BYTE     = 8'h00;
    localparam logic [15:0] BLOCK_LENGTH_RESET = 16'(50 * 1024);

    localparam logic [NBYTES_W-1:0] CONTROL_NBYTES = NBYTES_W'(3);
    localparam logic [NBYTES_W-1:0] BLOCK_NBYTES   = NBYTES_W'(7);

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] command_byte;
        logic [7:0] block_seq;
        logic [7:0] rx_first;
        logic [7:0] rx_second;
        logic [7:0] rx_third;
        logic       tx_ready;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_last;
        logic       sent_ok;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  head_byte;
        logic [7:0]  type_byte;
        logic [7:0]  snapshot_code;
        logic [7:0]  block_code;
        logic [15:0] block_length;
    } t_cfg;

    typedef struct packed {
        logic                                has_words;
        logic                                ok;
        logic [NBYTES_W-1:0]                 nbytes;
        logic [FRAME_MAX_BYTES-1:0][7:0]     bytes;
    } t_frame;

endpackage

// ----- src/ccf_decode.sv -----
// ----------------------------------------------------------------------------
// ccf_decode
// Turns one registered command item into a frame descriptor and computes the
// next value of the init acknowledge flag.
// ----------------------------------------------------------------------------
module ccf_decode
    import ccf_pkg::*;
(
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    input  logic     i_init_ack,
    output t_frame   o_frame,
    output logic     o_init_ack_next
);

    logic       is_ack;
    logic       do_ctrl;
    logic       do_block;
    logic [7:0] code;
    logic [7:0] seq;

    always_comb begin
        is_ack   = (i_item.rx_first == ACK_FIRST) && (i_item.rx_second == ACK_SECOND)
                   && (i_item.rx_third == ACK_THIRD);
        do_ctrl  = (i_item.cmd == CMD_CONTROL)
                   || ((i_item.cmd == CMD_RESPONSE) && is_ack && i_init_ack);
        do_block = (i_item.cmd == CMD_BLOCK)
                   || ((i_item.cmd == CMD_RESPONSE) && is_ack && !i_init_ack);
        code     = (i_item.cmd == CMD_CONTROL) ? i_item.command_byte : i_cfg.snapshot_code;
        seq      = (i_item.cmd == CMD_BLOCK) ? i_item.block_seq : 8'h00;

        o_init_ack_next = i_init_ack;
        if (do_ctrl && (code == CODE_INIT_SET)) begin
            o_init_ack_next = 1'b1;
        end else if (do_ctrl && (code == CODE_INIT_CLEAR)) begin
            o_init_ack_next = 1'b0;
        end

        o_frame.has_words = do_ctrl || do_block;
        o_frame.ok        = i_item.tx_ready;
        if (!i_item.tx_ready) begin
            o_frame.nbytes = '0;
        end else if (do_ctrl) begin
            o_frame.nbytes = CONTROL_NBYTES;
        end else begin
            o_frame.nbytes = BLOCK_NBYTES;
        end
        o_frame.bytes[0] = i_cfg.head_byte;
        o_frame.bytes[1] = i_cfg.type_byte;
        o_frame.bytes[2] = do_ctrl ? code : i_cfg.block_code;
        o_frame.bytes[3] = BLOCK_PAD_BYTE;
        o_frame.bytes[4] = seq;
        o_frame.bytes[5] = i_cfg.block_length[15:8];
        o_frame.bytes[6] = i_cfg.block_length[7:0];
    end

endmodule

// ----- src/ccf_serializer.sv -----
// ----------------------------------------------------------------------------
// ccf_serializer
// Holds one frame and sends it one word per cycle unless stalled, running the CRC-8
// (polynomial 0xD5, zero start, msb first) over the bytes as they leave.
// ----------------------------------------------------------------------------
module ccf_serializer
    import ccf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_frame    i_frame,
    output logic      o_free,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam logic [7:0] CRC_POLY = 8'hD5;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

    logic                            r_busy;
    logic                            r_ok;
    logic [NBYTES_W-1:0]             r_left;
    logic [7:0]                      r_crc;
    logic [FRAME_MAX_BYTES-1:0][7:0] r_bytes;

    logic fire;
    logic last_fire;

    assign fire      = r_busy && !i_out_stall;
    assign last_fire = fire && (r_left == '0);
    assign o_free    = !r_busy || last_fire;

    assign o_out_valid = r_busy;

    always_comb begin
        if (r_left != '0) begin
            o_out_item.tx_byte    = r_bytes[0];
            o_out_item.frame_last = 1'b0;
            o_out_item.sent_ok    = 1'b1;
        end else if (r_ok) begin
            o_out_item.tx_byte    = r_crc;
            o_out_item.frame_last = 1'b1;
            o_out_item.sent_ok    = 1'b1;
        end else begin
            o_out_item.tx_byte    = 8'h00;
            o_out_item.frame_last = 1'b1;
            o_out_item.sent_ok    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_left <= i_frame.nbytes;
        end else if (last_fire) begin
            r_busy <= 1'b0;
        end else if (fire) begin
            r_left <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ok    <= i_frame.ok;
            r_crc   <= 8'h00;
            r_bytes <= i_frame.bytes;
        end else if (fire && (r_left != '0)) begin
            r_crc   <= crc8_update(r_crc, r_bytes[0]);
            r_bytes <= {8'h00, r_bytes[FRAME_MAX_BYTES-1:1]};
        end
    end

endmodule

// ----- src/camera_command_framer_crc8.sv -----
// ----------------------------------------------------------------------------
// camera_command_framer_crc8
// Builds camera command frames with a trailing CRC-8 from command items.
//
// Input channel: one command item per word (control request, block request
// or received response), taken when i_in_valid is high and o_in_stall low.
// Output channel: one frame byte per word, with frame_last on the CRC byte;
// a request made while tx_ready is low gives a single refusal word instead.
// Configuration: write channel i_cfg_valid/o_cfg_ready (always ready), with
// register index and data; to be used only while the block is idle (not enforced).
// An accepted item is registered in the input register, then decoded and
// loaded into the frame register once the serializer is free.
// Throughput: one word per cycle unless the output stalls; a control frame is
// 4 words, a block frame 8, a refusal 1; a frame loads as the last one ends.
// A response that does not acknowledge, or an unused command, gives no word
// and leaves the input register without waiting for the serializer.
// A stall on the output holds the current word; the input register then
// fills and o_in_stall rises. Reset clears both registers, the init flag
// and loads the configuration defaults.
// ----------------------------------------------------------------------------
module camera_command_framer_crc8
    import ccf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg     r_cfg;
    logic     r_init_ack;
    logic     r_in_valid;
    t_in_item r_in_item;

    t_frame   frame;
    logic     n_init_ack;
    logic     ser_free;
    logic     consume;
    logic     load;

    assign o_cfg_ready = 1'b1;

    assign consume    = r_in_valid && (!frame.has_words || ser_free);
    assign load       = r_in_valid && frame.has_words && ser_free;
    assign o_in_stall = r_in_valid && !consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_byte     <= 8'h00;
            r_cfg.type_byte     <= 8'h00;
            r_cfg.snapshot_code <= 8'h00;
            r_cfg.block_code    <= 8'h00;
            r_cfg.block_length  <= BLOCK_LENGTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HEAD_BYTE:     r_cfg.head_byte     <= i_cfg_data[7:0];
                CFG_TYPE_BYTE:     r_cfg.type_byte     <= i_cfg_data[7:0];
                CFG_SNAPSHOT_CODE: r_cfg.snapshot_code <= i_cfg_data[7:0];
                CFG_BLOCK_CODE:    r_cfg.block_code    <= i_cfg_data[7:0];
                CFG_BLOCK_LENGTH:  r_cfg.block_length  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_init_ack <= 1'b0;
        end else begin
            if (consume) begin
                r_init_ack <= n_init_ack;
            end
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    ccf_decode u_decode (
        .i_item          (r_in_item),
        .i_cfg           (r_cfg),
        .i_init_ack      (r_init_ack),
        .o_frame         (frame),
        .o_init_ack_next (n_init_ack)
    );

    ccf_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_frame     (frame),
        .o_free      (ser_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
